// ===== rtl/core/mloc_pkg.sv =====
// shared types and codes for the motor lid open/close controller
// used by mloc_run_ctrl and motor_lid_open_close_controller; no dependencies
`default_nettype none

package mloc_pkg;

  // field widths
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned PROG_W    = 2;
  localparam int unsigned BOX_W     = 3;
  localparam int unsigned TIMEOUT_W = 16;
  localparam int unsigned TICKS_W   = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = TIMEOUT_W;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OPEN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLOSE = 2'd2;

  // progress codes
  localparam logic [PROG_W-1:0] PROG_NONE    = 2'd0;
  localparam logic [PROG_W-1:0] PROG_OPENING = 2'd1;
  localparam logic [PROG_W-1:0] PROG_CLOSING = 2'd2;
  localparam logic [PROG_W-1:0] PROG_BLOCKED = 2'd3;

  // box classification codes
  localparam logic [BOX_W-1:0] BOX_CLOSED    = 3'd0;
  localparam logic [BOX_W-1:0] BOX_OPEN_FULL = 3'd1;
  localparam logic [BOX_W-1:0] BOX_OPEN_HALF = 3'd2;
  localparam logic [BOX_W-1:0] BOX_BLOCKED   = 3'd3;
  localparam logic [BOX_W-1:0] BOX_FAIL      = 3'd4;

  // configuration register indexes and the timeout reset value
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RELAY_INVERT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT      = 1'd1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET        = 16'd30;

  // run phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_OPENING = 3'b010,
    PH_CLOSING = 3'b100
  } mloc_phase_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              closed_sensor;
    logic              opened_sensor;
    logic              blocked_sensor;
  } mloc_in_t;

  typedef struct packed {
    logic              opener_drive;
    logic              closer_drive;
    logic [PROG_W-1:0] progress;
    logic              finished;
    logic [BOX_W-1:0]  box_state;
  } mloc_out_t;

  typedef struct packed {
    logic                 relay_invert;
    logic [TIMEOUT_W-1:0] timeout_ticks;
  } mloc_cfg_t;

  // sensor priority: both limits, closed, blocked, full open, half open
  function automatic logic [BOX_W-1:0] classify_box(input logic cl, input logic op,
                                                    input logic bl);
    logic [BOX_W-1:0] box;
    if (op && cl) begin
      box = BOX_FAIL;
    end else if (cl) begin
      box = BOX_CLOSED;
    end else if (bl) begin
      box = BOX_BLOCKED;
    end else if (op) begin
      box = BOX_OPEN_FULL;
    end else begin
      box = BOX_OPEN_HALF;
    end
    return box;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mloc_run_ctrl.sv =====
// run state (phase and remaining ticks) and the per-item step logic
// depends on mloc_pkg
`default_nettype none

module mloc_run_ctrl
  import mloc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      fire,
  input  wire mloc_in_t  item,
  input  wire mloc_cfg_t cfg,
  output mloc_out_t      result
);

  mloc_phase_t         phase_r, phase_nxt;
  logic [TICKS_W-1:0]  ticks_left_r, ticks_left_nxt;
  logic [TICKS_W:0]    ext_sum;
  logic [TICKS_W-1:0]  ext_sat;
  logic [TICKS_W-1:0]  dec_base;
  logic                active;
  logic                target;
  logic [PROG_W-1:0]   progress;
  logic                finished;

  assign active = (phase_r == PH_OPENING) || (phase_r == PH_CLOSING);

  // blocked tick extends the allowance, saturating at all ones
  assign ext_sum  = {1'b0, ticks_left_r} + {{(TICKS_W + 1 - TIMEOUT_W){1'b0}}, cfg.timeout_ticks};
  assign ext_sat  = ext_sum[TICKS_W] ? {TICKS_W{1'b1}} : ext_sum[TICKS_W-1:0];
  assign dec_base = item.blocked_sensor ? ext_sat : ticks_left_r;
  assign target   = (phase_r == PH_OPENING) ? item.opened_sensor : item.closed_sensor;

  // step of one item
  always_comb begin
    phase_nxt      = active ? phase_r : PH_IDLE;
    ticks_left_nxt = ticks_left_r;
    progress       = PROG_NONE;
    finished       = 1'b0;
    case (item.mode)
      MODE_TICK: begin
        if (active) begin
          if (target || (ticks_left_r == '0)) begin
            phase_nxt = PH_IDLE;
            finished  = 1'b1;
          end else begin
            ticks_left_nxt = dec_base - {{(TICKS_W - 1){1'b0}}, 1'b1};
            if (item.blocked_sensor) begin
              progress = PROG_BLOCKED;
            end else if (phase_r == PH_OPENING) begin
              progress = PROG_OPENING;
            end else begin
              progress = PROG_CLOSING;
            end
          end
        end
      end
      MODE_OPEN: begin
        if (!active) begin
          if (item.opened_sensor) begin
            finished = 1'b1;
          end else begin
            phase_nxt      = PH_OPENING;
            ticks_left_nxt = {{(TICKS_W - TIMEOUT_W){1'b0}}, cfg.timeout_ticks};
          end
        end
      end
      MODE_CLOSE: begin
        if (!active) begin
          if (item.closed_sensor || item.blocked_sensor) begin
            finished = 1'b1;
          end else begin
            phase_nxt      = PH_CLOSING;
            ticks_left_nxt = {{(TICKS_W - TIMEOUT_W){1'b0}}, cfg.timeout_ticks};
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result fields from the updated phase and the current sensors
  always_comb begin
    result.opener_drive = (phase_nxt == PH_OPENING) ^ cfg.relay_invert;
    result.closer_drive = (phase_nxt == PH_CLOSING) ^ cfg.relay_invert;
    result.progress     = progress;
    result.finished     = finished;
    result.box_state    = classify_box(item.closed_sensor, item.opened_sensor,
                                       item.blocked_sensor);
  end

  // state registers, advanced once per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      ticks_left_r <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      ticks_left_r <= ticks_left_nxt;
    end
  end

  // a run end or rejection never reports progress
  a_finished_no_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && result.finished) |-> (result.progress == PROG_NONE))
    else $error("finished item reports progress");

  // accepted open command from idle loads the allowance
  a_open_start: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && item.mode == MODE_OPEN && !active && !item.opened_sensor)
    |=> (phase_r == PH_OPENING)
        && (ticks_left_r == {{(TICKS_W - TIMEOUT_W){1'b0}}, $past(cfg.timeout_ticks)}))
    else $error("open command did not start a run");

  // state only moves on a transfer
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(phase_r) && $stable(ticks_left_r)))
    else $error("run state changed without a transfer");

endmodule

`default_nettype wire

// ===== rtl/core/motor_lid_open_close_controller.sv =====
// top level: input register, result register, configuration registers
// depends on mloc_pkg and mloc_run_ctrl
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall  | mloc_in_t  in_data
//  out_    | output    | out_valid / out_stall| mloc_out_t out_data
//  cfg_    | input     | cfg_wr_en            | cfg_index, cfg_wdata
//
// one item per cycle while out_stall is low; a result passes the input register,
// then the result register, and the step logic sits between them
// synchronous active-low reset clears both valids, the run phase (idle), the
// remaining ticks and the registers (relay_invert 0, timeout_ticks 30)
// out_stall holds the result register and, when the input register is also
// full, raises in_stall in the same cycle
`default_nettype none

module motor_lid_open_close_controller
  import mloc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire mloc_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output mloc_out_t                  out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic      s1_valid_r;
  mloc_in_t  s1_item_r;
  logic      out_valid_r;
  mloc_out_t out_data_r;
  mloc_cfg_t cfg_r;
  mloc_out_t step_result;
  logic      s2_ready;
  logic      s1_ready;
  logic      fire;

  // flow control
  assign s2_ready = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && s2_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.relay_invert  <= 1'b0;
      cfg_r.timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IDX_RELAY_INVERT: cfg_r.relay_invert  <= cfg_wdata[0];
        CFG_IDX_TIMEOUT:      cfg_r.timeout_ticks <= cfg_wdata[TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mloc_run_ctrl u_run_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .result (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result only appears after a filled input register
  a_out_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result without an input item");

  // a held input item is neither lost nor altered
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input register lost an item");

  // a stalled result is kept, still valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("stalled result changed");

endmodule

`default_nettype wire
